[rtl/core/wsfe_pkg.sv]
// Shared types, constants and helpers for the WebSocket frame encoder.
package wsfe_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 63;
    localparam int KEY_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int HDR_BYTES   = 14;
    localparam int HDR_W       = 8 * HDR_BYTES;
    localparam int HCNT_W      = $clog2(HDR_BYTES + 1);

    localparam logic [7:0]  HDR0       = 8'h81;
    localparam logic [6:0]  LEN16_CODE = 7'h7E;
    localparam logic [6:0]  LEN64_CODE = 7'h7F;
    localparam logic [15:0] LEN16_MAX  = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY     = 1'b1;

    typedef enum logic [1:0] {
        LEN_SHORT = 2'd0,
        LEN_MID   = 2'd1,
        LEN_LONG  = 2'd2
    } t_len_cls;

    typedef struct packed {
        logic              start;
        logic              carries;
        logic              mbit;
        t_len_cls          len_cls;
        logic [LEN_W-1:0]  len;
        logic [KEY_W-1:0]  key;
        logic [BYTE_W-1:0] pbyte;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic hdr_active;
    } t_back_stat;

    function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                            input logic [1:0] phase);
        logic [7:0] b;
        case (phase)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            2'd3:    b = key[7:0];
            default: b = key[31:24];
        endcase
        return b;
    endfunction

endpackage

[rtl/core/wsfe_intf.sv]
// Handshake interfaces for the encoder's input, output and configuration channels.
interface wsfe_in_if;
    import wsfe_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              carries_byte;
    logic              frame_start;
    logic [LEN_W-1:0]  frame_length;

    modport source (output valid, payload_byte, carries_byte, frame_start, frame_length,
                    input ready);
    modport sink   (input valid, payload_byte, carries_byte, frame_start, frame_length,
                    output ready);
endinterface

interface wsfe_out_if;
    import wsfe_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_header;
    logic              run_last;

    modport source (output valid, out_byte, is_header, run_last, input ready);
    modport sink   (input valid, out_byte, is_header, run_last, output ready);
endinterface

interface wsfe_cfg_if;
    import wsfe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/wsfe_front.sv]
// Front end: config registers, input accept, length classing and payload masking.
module wsfe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wsfe_in_if.sink        i_in,
    wsfe_cfg_if.sink       i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output wsfe_pkg::t_desc o_desc
);
    import wsfe_pkg::*;

    logic             r_mask_enable, n_mask_enable;
    logic [KEY_W-1:0] r_xor_key, n_xor_key;
    logic [1:0]       r_key_phase, n_key_phase;
    logic             in_fire;
    logic [1:0]       phase_use;
    t_len_cls         len_cls;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign in_fire     = i_in.valid && i_in.ready;

    // Key phase restarts on a frame start, before that item's payload byte.
    assign phase_use = i_in.frame_start ? 2'd0 : r_key_phase;

    always_comb begin
        if (i_in.frame_length < LEN_W'(LEN16_CODE)) begin
            len_cls = LEN_SHORT;
        end else if (i_in.frame_length <= LEN_W'(LEN16_MAX)) begin
            len_cls = LEN_MID;
        end else begin
            len_cls = LEN_LONG;
        end
    end

    always_comb begin
        o_desc.start   = i_in.frame_start;
        o_desc.carries = i_in.carries_byte;
        o_desc.mbit    = r_mask_enable;
        o_desc.len_cls = len_cls;
        o_desc.len     = i_in.frame_length;
        o_desc.key     = r_xor_key;
        o_desc.pbyte   = i_in.payload_byte
                       ^ (r_mask_enable ? key_byte(r_xor_key, phase_use) : 8'h00);
    end

    // Drop empty beats; everything else goes to the queue.
    assign o_push = in_fire && (i_in.frame_start || i_in.carries_byte);

    always_comb begin
        n_key_phase   = r_key_phase;
        n_mask_enable = r_mask_enable;
        n_xor_key     = r_xor_key;
        if (in_fire) begin
            n_key_phase = i_in.carries_byte ? phase_use + 2'd1 : phase_use;
        end
        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MASK_ENABLE: n_mask_enable = i_cfg.data[0];
                CFG_XOR_KEY:     n_xor_key     = i_cfg.data[KEY_W-1:0];
                default:         n_mask_enable = r_mask_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_enable <= 1'b0;
            r_xor_key     <= '0;
            r_key_phase   <= 2'd0;
        end else begin
            r_mask_enable <= n_mask_enable;
            r_xor_key     <= n_xor_key;
            r_key_phase   <= n_key_phase;
        end
    end

endmodule

[rtl/core/wsfe_queue.sv]
// Short descriptor queue between the front end and the byte serializer.
module wsfe_queue #(
    parameter int DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wsfe_pkg::t_desc    i_desc,
    input  logic               i_pop,
    output wsfe_pkg::t_desc    o_desc,
    output wsfe_pkg::t_q_stat  o_stat
);
    import wsfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_desc       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/core/wsfe_back.sv]
// Back end: descriptor to header and payload bytes, one per cycle unless o_out stalls.
module wsfe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  wsfe_pkg::t_desc      i_desc,
    output logic                 o_pop,
    output wsfe_pkg::t_back_stat o_stat,
    wsfe_out_if.source           o_out
);
    import wsfe_pkg::*;

    logic              r_busy, n_busy;
    logic [HDR_W-1:0]  r_hdr, n_hdr;
    logic [HCNT_W-1:0] r_hcnt, n_hcnt;
    logic              r_carries, n_carries;
    logic [BYTE_W-1:0] r_pbyte, n_pbyte;
    logic              r_ov, n_ov;
    logic [BYTE_W-1:0] r_ob, n_ob;
    logic              r_oh, n_oh;
    logic              r_ol, n_ol;

    logic              take, emit, hdr_emit, em_last, finish;
    logic [HDR_W-1:0]  ld_hdr;
    logic [HCNT_W-1:0] ld_hcnt;
    logic [HCNT_W-1:0] ext_cnt;

    // Build the left-aligned header image for the descriptor at the queue head.
    always_comb begin
        case (i_desc.len_cls)
            LEN_SHORT: begin
                ld_hdr  = {HDR0, i_desc.mbit, i_desc.len[6:0], i_desc.key, 64'h0};
                ext_cnt = HCNT_W'(2);
            end
            LEN_MID: begin
                ld_hdr  = {HDR0, i_desc.mbit, LEN16_CODE, i_desc.len[15:0],
                           i_desc.key, 48'h0};
                ext_cnt = HCNT_W'(4);
            end
            LEN_LONG: begin
                ld_hdr  = {HDR0, i_desc.mbit, LEN64_CODE, 1'b0, i_desc.len, i_desc.key};
                ext_cnt = HCNT_W'(10);
            end
            default: begin
                ld_hdr  = {HDR0, i_desc.mbit, LEN64_CODE, 1'b0, i_desc.len, i_desc.key};
                ext_cnt = HCNT_W'(10);
            end
        endcase
        if (!i_desc.start) begin
            ld_hcnt = '0;
        end else begin
            ld_hcnt = ext_cnt + (i_desc.mbit ? HCNT_W'(4) : HCNT_W'(0));
        end
    end

    assign take     = !r_ov || o_out.ready;
    assign emit     = r_busy && take;
    assign hdr_emit = (r_hcnt != '0);
    assign em_last  = hdr_emit ? ((r_hcnt == HCNT_W'(1)) && !r_carries) : 1'b1;
    assign finish   = emit && em_last;
    // Refill as the last byte leaves, same cycle; unstalled payload runs one per cycle.
    assign o_pop    = !i_q_empty && (!r_busy || finish);

    always_comb begin
        n_busy    = r_busy;
        n_hdr     = r_hdr;
        n_hcnt    = r_hcnt;
        n_carries = r_carries;
        n_pbyte   = r_pbyte;
        n_ov      = r_ov;
        n_ob      = r_ob;
        n_oh      = r_oh;
        n_ol      = r_ol;

        if (emit) begin
            n_ov = 1'b1;
            n_ob = hdr_emit ? r_hdr[HDR_W-1 -: BYTE_W] : r_pbyte;
            n_oh = hdr_emit;
            n_ol = em_last;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end

        if (o_pop) begin
            n_busy    = 1'b1;
            n_hdr     = ld_hdr;
            n_hcnt    = ld_hcnt;
            n_carries = i_desc.carries;
            n_pbyte   = i_desc.pbyte;
        end else begin
            if (finish) begin
                n_busy = 1'b0;
            end
            if (emit && hdr_emit) begin
                n_hdr  = {r_hdr[HDR_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                n_hcnt = r_hcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_hcnt <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_hcnt <= n_hcnt;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr     <= n_hdr;
        r_carries <= n_carries;
        r_pbyte   <= n_pbyte;
        r_ob      <= n_ob;
        r_oh      <= n_oh;
        r_ol      <= n_ol;
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_byte  = r_ob;
    assign o_out.is_header = r_oh;
    assign o_out.run_last  = r_ol;

    assign o_stat.busy       = r_busy;
    assign o_stat.hdr_active = hdr_emit;

endmodule

[rtl/core/websocket_frame_encoder_top.sv]
// Top level of the WebSocket text frame encoder.
//
//  channel  dir   handshake        beat contents
//  i_in     in    valid / ready    payload_byte, carries_byte, frame_start, frame_length
//  o_out    out   valid / ready    out_byte, is_header, run_last
//  i_cfg    in    valid / ready    index (0 mask_enable, 1 xor key), data
//
// Payload-only items flow at one per cycle while o_out does not stall. A frame start
// item emits 2 to 14 header beats, paced by the byte serializer's one byte per cycle
// under the same condition; the descriptor queue (QUEUE_DEPTH entries) keeps taking
// items during that burst until it fills. Items pass the descriptor queue, the
// serializer and the output register in that order. Reset clears the config
// registers, key phase, queue and output valid. i_in stalls only when the queue is
// full; o_out stalls hold the output register and back up into the queue.
module websocket_frame_encoder_top #(
    parameter int QUEUE_DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfe_in_if.sink     i_in,
    wsfe_cfg_if.sink    i_cfg,
    wsfe_out_if.source  o_out
);
    import wsfe_pkg::*;

    logic       push, pop;
    t_desc      front_desc, head_desc;
    t_q_stat    q_stat;
    t_back_stat back_stat;

    wsfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_desc   (front_desc)
    );

    wsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .i_pop   (pop),
        .o_desc  (head_desc),
        .o_stat  (q_stat)
    );

    wsfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_stat.empty),
        .i_desc    (head_desc),
        .o_pop     (pop),
        .o_stat    (back_stat),
        .o_out     (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("descriptor pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("descriptor popped from an empty queue");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> back_stat.busy)
        else $error("serializer idle after taking a descriptor");

    a_hdr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.hdr_active |-> back_stat.busy)
        else $error("header bytes pending with no descriptor loaded");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule
